// ===== hdl/ffs_pkg.sv =====
// Shared types, widths and codes for the firefly slot sync node.
// No dependencies; every other file of the block imports this package.
package ffs_pkg;

  // Field widths
  localparam int unsigned PH_W       = 10;  // phase, times and slots
  localparam int unsigned ID_W       = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Defaults for the top level parameters
  localparam int unsigned DEF_PERIOD = 1024;
  localparam int unsigned DEF_BURSTS = 4;

  // Advance reduction: quotient by reciprocal, exact for any 10 bit advance
  localparam int unsigned ADV_SHIFT   = 20;
  localparam int unsigned ADV_RECIP_W = 17;
  localparam int unsigned ADV_PROD_W  = PH_W + ADV_RECIP_W;
  localparam int unsigned ADV_QUOT_W  = 7;   // 1023 / 10 at the smallest period

  // Division by five: reciprocal 2^16/5 rounded up, exact below 2^14
  localparam int unsigned          DIV5_SHIFT  = 16;
  localparam int unsigned          DIV5_RECIP_W = 14;
  localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 14'd13108;
  localparam int unsigned          DIV5_PROD_W = PH_W + DIV5_RECIP_W;
  localparam int unsigned          DELTA_W     = 8;   // 1023 / 5 fits in 8 bits
  localparam int unsigned          DELTA_N     = 2 ** DELTA_W;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECV    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOT = 2'd1;

  // Reported mode codes
  localparam logic [MODE_W-1:0] MODE_CODE_BCAST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_QUIET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_LISTEN = 2'd2;

  // Node mode, one-hot
  typedef enum logic [2:0] {
    MODE_BCAST  = 3'b001,
    MODE_QUIET  = 3'b010,
    MODE_LISTEN = 3'b100
  } mode_t;

  // One event beat as held in the input register
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [PH_W-1:0]       advance;
    logic [ID_W-1:0]       sender_id;
    logic [PH_W-1:0]       sender_time;
    logic                  sender_last;
    logic [PH_W-1:0]       random_slot;
    logic [ADV_QUOT_W-1:0] adv_quot;
  } evt_beat_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_BCAST:  c = MODE_CODE_BCAST;
      MODE_QUIET:  c = MODE_CODE_QUIET;
      MODE_LISTEN: c = MODE_CODE_LISTEN;
      default:     c = MODE_CODE_BCAST;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/ffs_evt_if.sv =====
// Event channel: valid/ready handshake with the event fields.
// Depends on ffs_pkg for field widths.
interface ffs_evt_if import ffs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [PH_W-1:0]       advance;
  logic [ID_W-1:0]       sender_id;
  logic [PH_W-1:0]       sender_time;
  logic                  sender_last;
  logic [PH_W-1:0]       random_slot;

  modport source (
    output valid, kind, advance, sender_id, sender_time, sender_last, random_slot,
    input  ready
  );
  modport sink (
    input  valid, kind, advance, sender_id, sender_time, sender_last, random_slot,
    output ready
  );
endinterface

// ===== hdl/ffs_res_if.sv =====
// Result channel: valid/ready handshake with the result fields.
// Depends on ffs_pkg for field widths.
interface ffs_res_if import ffs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [PH_W-1:0]   send_time;
  logic              send_last;
  logic              blink;
  logic [MODE_W-1:0] mode;
  logic [PH_W-1:0]   phase;

  modport source (
    output valid, send_valid, send_time, send_last, blink, mode, phase,
    input  ready
  );
  modport sink (
    input  valid, send_valid, send_time, send_last, blink, mode, phase,
    output ready
  );
endinterface

// ===== hdl/firefly_slot_sync_node.sv =====
// Top level of the firefly slot sync node: input register and core.
// Depends on ffs_pkg, ffs_evt_if, ffs_res_if, ffs_in_stage and ffs_core.
//
//   channel  dir  beat fields                                            handshake
//   evt      in   kind advance sender_id sender_time sender_last random_slot  valid/ready
//   res      out  send_valid send_time send_last blink mode phase          valid/ready
//   cfg      in   cfg_index cfg_data                                       cfg_wr strobe
//
// One event beat per cycle while the result side keeps up; each beat gives one result
// beat once it has passed the input register, then the state update into the result register.
// Reset is synchronous on rst; no clearing pass.
// A stalled result holds the result register; one more event beat waits in the
// input register, and evt.ready drops only when both are full.
module firefly_slot_sync_node import ffs_pkg::*; #(
  parameter int unsigned PERIOD = DEF_PERIOD,
  parameter int unsigned BURSTS = DEF_BURSTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ffs_evt_if.sink               evt,
  ffs_res_if.source             res
);

  logic      stg_vld;
  logic      stg_take;
  evt_beat_t stg_beat;

  // Input register
  ffs_in_stage #(
    .PERIOD (PERIOD)
  ) u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .evt  (evt),
    .take (stg_take),
    .vld  (stg_vld),
    .beat (stg_beat)
  );

  // State update and result register
  ffs_core #(
    .PERIOD (PERIOD),
    .BURSTS (BURSTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vld       (stg_vld),
    .beat      (stg_beat),
    .take      (stg_take),
    .res       (res)
  );

endmodule

// ===== hdl/ffs_in_stage.sv =====
// Input register of the node: takes one event beat and precomputes the
// quotient advance / PERIOD. Depends on ffs_pkg and ffs_evt_if.
module ffs_in_stage import ffs_pkg::*; #(
  parameter int unsigned PERIOD = DEF_PERIOD
) (
  input  logic       clk,
  input  logic       rst,
  ffs_evt_if.sink    evt,
  input  logic       take,
  output logic       vld,
  output evt_beat_t  beat
);

  localparam logic [ADV_RECIP_W-1:0] ADV_RECIP =
    ADV_RECIP_W'((2 ** ADV_SHIFT + PERIOD - 1) / PERIOD);

  logic [ADV_PROD_W-1:0] adv_prod;
  logic                  accept;

  // Open for a new beat when empty or when the held beat moves on
  assign evt.ready = !vld || take;
  assign accept    = evt.valid && evt.ready;

  // Quotient of the advance by the period, by reciprocal
  assign adv_prod = ADV_PROD_W'(evt.advance) * ADV_PROD_W'(ADV_RECIP);

  // Hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (accept) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (accept) begin
      beat.kind        <= evt.kind;
      beat.advance     <= evt.advance;
      beat.sender_id   <= evt.sender_id;
      beat.sender_time <= evt.sender_time;
      beat.sender_last <= evt.sender_last;
      beat.random_slot <= evt.random_slot;
      beat.adv_quot    <= adv_prod[ADV_SHIFT +: ADV_QUOT_W];
    end
  end

endmodule

// ===== hdl/ffs_core.sv =====
// Node state, configuration registers, the one-step update and the result
// register. Depends on ffs_pkg and ffs_res_if.
module ffs_core import ffs_pkg::*; #(
  parameter int unsigned PERIOD = DEF_PERIOD,
  parameter int unsigned BURSTS = DEF_BURSTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  vld,
  input  evt_beat_t             beat,
  output logic                  take,
  ffs_res_if.source             res
);

  localparam logic [PH_W:0]    PERIOD_W = (PH_W + 1)'(PERIOD);
  localparam logic [CNT_W-1:0] BURSTS_W = CNT_W'(BURSTS);
  localparam int unsigned      ADV_MUL_W = ADV_QUOT_W + PH_W + 1;

  // State
  logic [PH_W-1:0]  phase_count, phase_count_next;
  mode_t            node_mode, node_mode_next;
  logic [PH_W-1:0]  send_slot, send_slot_next;
  logic [CNT_W-1:0] sent_count, sent_count_next;
  logic             cycle_done, cycle_done_next;
  logic [ID_W-1:0]  node_id;

  // Step results
  logic             sv, sl, blink;
  logic [PH_W-1:0]  st;
  logic             leave_bcast;

  // Advance path
  logic [ADV_MUL_W-1:0] adv_mul;
  logic [PH_W-1:0]      adv_rem;
  logic [PH_W:0]        adv_sum;
  logic [PH_W-1:0]      adv_phase;

  // Nudge path
  logic signed [PH_W:0]   diff;
  logic [PH_W-1:0]        diff_mag;
  logic [DIV5_PROD_W-1:0] div5_prod;
  logic [DELTA_W-1:0]     delta_mag;
  logic [PH_W-1:0]        delta_mod;
  logic [PH_W:0]          nudge_sum;
  logic [PH_W-1:0]        nudge_phase;
  logic [PH_W-1:0]        dmod_tbl [DELTA_N];

  logic [CNT_W-1:0]       sent_inc;

  // Constant table of i mod PERIOD for the positive nudge
  for (genvar i = 0; i < DELTA_N; i++) begin : g_dmod
    localparam int unsigned DM = i % PERIOD;
    assign dmod_tbl[i] = PH_W'(DM);
  end

  // Move a beat on when the result register is free or being emptied
  assign take = vld && (!res.valid || res.ready);

  // Advance: remainder of the advance, then one wrap of the sum
  assign adv_mul   = ADV_MUL_W'(beat.adv_quot) * ADV_MUL_W'(PERIOD_W);
  assign adv_rem   = beat.advance - adv_mul[PH_W-1:0];
  assign adv_sum   = {1'b0, phase_count} + {1'b0, adv_rem};
  assign adv_phase = (adv_sum >= PERIOD_W) ? PH_W'(adv_sum - PERIOD_W) : adv_sum[PH_W-1:0];

  // Nudge: (sender_time - phase) / 5 toward zero; a backward step never
  // goes below zero since its size is at most phase / 5
  assign diff      = $signed({1'b0, beat.sender_time}) - $signed({1'b0, phase_count});
  assign diff_mag  = diff[PH_W] ? PH_W'(-diff) : PH_W'(diff);
  assign div5_prod = DIV5_PROD_W'(diff_mag) * DIV5_PROD_W'(DIV5_RECIP);
  assign delta_mag = div5_prod[DIV5_SHIFT +: DELTA_W];
  assign delta_mod = dmod_tbl[delta_mag];
  assign nudge_sum = {1'b0, phase_count} + {1'b0, delta_mod};

  always_comb begin
    if (diff[PH_W]) begin
      nudge_phase = phase_count - PH_W'(delta_mag);
    end else if (nudge_sum >= PERIOD_W) begin
      nudge_phase = PH_W'(nudge_sum - PERIOD_W);
    end else begin
      nudge_phase = nudge_sum[PH_W-1:0];
    end
  end

  assign sent_inc = sent_count + CNT_W'(1);

  // Next state for the held beat
  always_comb begin
    phase_count_next = phase_count;
    node_mode_next   = node_mode;
    send_slot_next   = send_slot;
    sent_count_next  = sent_count;
    cycle_done_next  = cycle_done;
    sv               = 1'b0;
    st               = '0;
    sl               = 1'b0;
    blink            = 1'b0;
    leave_bcast      = 1'b0;

    case (beat.kind)
      KIND_ADVANCE: begin
        phase_count_next = adv_phase;
        blink            = adv_phase < phase_count;
      end
      KIND_SEND: begin
        if (node_mode == MODE_BCAST && !cycle_done && phase_count >= send_slot) begin
          sent_count_next = sent_inc;
          sv              = 1'b1;
          st              = phase_count;
          sl              = (sent_inc == BURSTS_W);
        end
        cycle_done_next = 1'b1;
        if (sent_count_next == BURSTS_W) begin
          leave_bcast    = (node_mode == MODE_BCAST);
          node_mode_next = MODE_QUIET;
        end
      end
      KIND_RECV: begin
        phase_count_next = nudge_phase;
        blink            = nudge_phase < phase_count;
        if ((node_mode == MODE_BCAST || node_mode == MODE_QUIET) &&
            beat.sender_id < node_id) begin
          leave_bcast    = (node_mode == MODE_BCAST);
          node_mode_next = MODE_LISTEN;
        end else if (node_mode == MODE_LISTEN &&
                     (beat.sender_id > node_id ||
                      (node_id != '0 && beat.sender_id == node_id - ID_W'(1) &&
                       beat.sender_last))) begin
          node_mode_next = MODE_BCAST;
        end
      end
      default: begin
      end
    endcase

    // Drop the burst and draw a fresh slot on leaving broadcasting
    if (leave_bcast) begin
      sent_count_next = '0;
      cycle_done_next = 1'b0;
      send_slot_next  = beat.random_slot;
    end

    // A new cycle re-arms sending
    if (blink) begin
      cycle_done_next = 1'b0;
    end
  end

  // Advance state; configuration writes are to come while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      node_mode   <= MODE_BCAST;
      send_slot   <= '0;
      sent_count  <= '0;
      cycle_done  <= 1'b0;
      node_id     <= '0;
    end else begin
      if (take) begin
        phase_count <= phase_count_next;
        node_mode   <= node_mode_next;
        send_slot   <= send_slot_next;
        sent_count  <= sent_count_next;
        cycle_done  <= cycle_done_next;
      end
      if (cfg_wr) begin
        case (cfg_index)
          REG_NODE_ID:    node_id   <= cfg_data[ID_W-1:0];
          REG_START_SLOT: send_slot <= cfg_data[PH_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Hold result valid until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res.send_valid <= sv;
      res.send_time  <= st;
      res.send_last  <= sl;
      res.blink      <= blink;
      res.mode       <= mode_code(node_mode_next);
      res.phase      <= phase_count_next;
    end
  end

endmodule

// ===== bench/firefly_slot_sync_node_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for firefly_slot_sync_node: a directed event table, then random traffic.
// Depends on ffs_pkg, ffs_evt_if, ffs_res_if and the node RTL; needs no files at run time.
module firefly_slot_sync_node_test;
  import ffs_pkg::*;

  localparam int unsigned SYNC_PERIOD    = DEF_PERIOD;
  localparam int unsigned BURST_LEN      = DEF_BURSTS;
  localparam int          NUDGE_DIV      = 5;     // nudge is a fifth of the phase error
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned SQUEEZE_CYCLES = 150;
  localparam int unsigned SQUEEZE_EVENTS = 60;
  localparam int unsigned PHASE_EVENTS   = 155;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned SQUEEZE_PHASE  = 2;

  // Codes outside the block's defined set
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PH_W-1:0]   advance;
    logic [ID_W-1:0]   sender_id;
    logic [PH_W-1:0]   sender_time;
    logic              sender_last;
    logic [PH_W-1:0]   random_slot;
  } event_t;

  typedef struct packed {
    logic              send_valid;
    logic [PH_W-1:0]   send_time;
    logic              send_last;
    logic              blink;
    logic [MODE_W-1:0] mode;
    logic [PH_W-1:0]   phase;
  } outcome_t;

  typedef struct packed {
    event_t   ev;
    logic     typed;
    outcome_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ffs_evt_if evt ();
  ffs_res_if res ();

  firefly_slot_sync_node #(.PERIOD(SYNC_PERIOD), .BURSTS(BURST_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Predicted node state and configuration
  logic [PH_W-1:0]   node_ph;
  logic [MODE_W-1:0] node_md;
  logic [PH_W-1:0]   node_slot;
  logic [CNT_W-1:0]  node_sent;
  logic              node_done;
  logic [ID_W-1:0]   node_addr;

  outcome_t pending_outcomes[$];

  int unsigned failures = 0;
  int unsigned events_sent = 0;
  int unsigned results_checked = 0;
  int unsigned sends_seen = 0;
  int unsigned blinks_seen = 0;
  int unsigned settings_used = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_left = 0;
  bit          tx_tight = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  // Leaving broadcasting re-arms the burst and takes the fresh slot
  function automatic void switch_mode(input logic [MODE_W-1:0] nxt,
                                      input logic [PH_W-1:0] fresh);
    if (node_md == MODE_CODE_BCAST) begin
      node_sent = '0;
      node_done = 1'b0;
      node_slot = fresh;
    end
    node_md = nxt;
  endfunction

  // Advance the predicted node by one event and return its result beat
  function automatic outcome_t node_step(input event_t e);
    outcome_t    o;
    int          p;
    int          d;
    int          sum;
    int unsigned nxt;
    o = '0;
    p = int'(node_ph);
    case (e.kind)
      KIND_ADVANCE: begin
        nxt = (p + e.advance) % SYNC_PERIOD;
        node_ph = nxt[PH_W-1:0];
        o.blink = (nxt < p);
      end
      KIND_SEND: begin
        if (node_md == MODE_CODE_BCAST && !node_done && node_ph >= node_slot) begin
          node_sent = node_sent + 1'b1;
          o.send_valid = 1'b1;
          o.send_time = node_ph;
          o.send_last = (node_sent == BURST_LEN);
        end
        node_done = 1'b1;
        if (node_sent == BURST_LEN) switch_mode(MODE_CODE_QUIET, e.random_slot);
      end
      KIND_RECV: begin
        // truncate toward zero, then fold back into the period
        d = (int'(e.sender_time) - p) / NUDGE_DIV;
        sum = p + d;
        if (sum < 0) sum = sum + int'(SYNC_PERIOD);
        nxt = sum % SYNC_PERIOD;
        node_ph = nxt[PH_W-1:0];
        o.blink = (d < 0) || (nxt < p);
        if ((node_md == MODE_CODE_BCAST || node_md == MODE_CODE_QUIET) &&
            e.sender_id < node_addr) begin
          switch_mode(MODE_CODE_LISTEN, e.random_slot);
        end else if (node_md == MODE_CODE_LISTEN &&
                     (e.sender_id > node_addr ||
                      (node_addr != '0 && e.sender_id == node_addr - 1'b1 &&
                       e.sender_last))) begin
          switch_mode(MODE_CODE_BCAST, e.random_slot);
        end
      end
      default: ;
    endcase
    if (o.blink) node_done = 1'b0;
    o.mode = node_md;
    o.phase = node_ph;
    return o;
  endfunction

  function automatic event_t mk_ev(input logic [KIND_W-1:0] kind, input int adv,
                                   input int sid, input int stime, input int slast,
                                   input int rslot);
    event_t e;
    e.kind = kind;
    e.advance = PH_W'(adv);
    e.sender_id = ID_W'(sid);
    e.sender_time = PH_W'(stime);
    e.sender_last = 1'(slast);
    e.random_slot = PH_W'(rslot);
    return e;
  endfunction

  function automatic outcome_t mk_res(input int sv, input int st, input int sl, input int bl,
                                      input logic [MODE_W-1:0] md, input int ph);
    outcome_t o;
    o.send_valid = 1'(sv);
    o.send_time = PH_W'(st);
    o.send_last = 1'(sl);
    o.blink = 1'(bl);
    o.mode = md;
    o.phase = PH_W'(ph);
    return o;
  endfunction

  function automatic dir_row_t mk_row(input event_t e, input int typed, input outcome_t want);
    dir_row_t r;
    r.ev = e;
    r.typed = 1'(typed);
    r.want = want;
    return r;
  endfunction

  // Mostly well-formed traffic: ticks, send attempts and messages from neighbors
  function automatic event_t rand_event();
    event_t      e;
    int unsigned r;
    e.advance = PH_W'($urandom_range(0, 1023));
    e.sender_id = ID_W'($urandom_range(0, 15));
    e.sender_time = PH_W'($urandom_range(0, 1023));
    e.sender_last = 1'($urandom_range(0, 1));
    e.random_slot = PH_W'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < 38) e.kind = KIND_ADVANCE;
    else if (r < 72) e.kind = KIND_SEND;
    else if (r < 96) e.kind = KIND_RECV;
    else e.kind = KIND_UNUSED;
    r = $urandom_range(0, 9);
    if (r < 4) e.advance = PH_W'($urandom_range(0, 127));
    else if (r == 4) e.advance = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    r = $urandom_range(0, 9);
    if (r < 4) e.sender_id = node_addr - 1'b1;
    else if (r < 6) e.sender_id = node_addr + 1'b1;
    else if (r == 6) e.sender_id = node_addr;
    if ($urandom_range(0, 9) < 7) e.random_slot = PH_W'($urandom_range(0, 255));
    return e;
  endfunction

  // Offer one event beat, hold it until accepted, then log what it must produce
  task automatic offer(input event_t e, input bit no_gap, input bit typed,
                       input outcome_t want);
    int unsigned gap;
    outcome_t    predicted;
    if (tx_left == 0) begin
      tx_left = $urandom_range(8, 40);
      tx_tight = ($urandom_range(0, 3) == 0);
    end
    tx_left--;
    gap = (no_gap || tx_tight) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt.valid <= 1'b1;
    evt.kind <= e.kind;
    evt.advance <= e.advance;
    evt.sender_id <= e.sender_id;
    evt.sender_time <= e.sender_time;
    evt.sender_last <= e.sender_last;
    evt.random_slot <= e.random_slot;
    do begin
      @(posedge clk);
      if (!evt.ready) stall_cycles++;
    end while (!evt.ready);
    predicted = node_step(e);
    pending_outcomes.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  // Drop valid and wait until the node has drained
  task automatic settle();
    evt.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_NODE_ID:    node_addr = val[ID_W-1:0];
      REG_START_SLOT: node_slot = val[PH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_outcome(input outcome_t got);
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      $error("result beat with nothing pending: phase %0d", got.phase);
      failures++;
    end else begin
      want = pending_outcomes.pop_front();
      results_checked++;
      if (want.send_valid) sends_seen++;
      if (want.blink) blinks_seen++;
      if (got.send_valid !== want.send_valid) begin
        $error("send_valid: expected %0d, got %0d", want.send_valid, got.send_valid);
        failures++;
      end
      if (got.send_time !== want.send_time) begin
        $error("send_time: expected %0d, got %0d", want.send_time, got.send_time);
        failures++;
      end
      if (got.send_last !== want.send_last) begin
        $error("send_last: expected %0d, got %0d", want.send_last, got.send_last);
        failures++;
      end
      if (got.blink !== want.blink) begin
        $error("blink: expected %0d, got %0d", want.blink, got.blink);
        failures++;
      end
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        failures++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        failures++;
      end
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned hold;
    int unsigned rx_left;
    bit          rx_tight;
    outcome_t    got;
    rx_left = 0;
    rx_tight = 1'b0;
    res.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(8, 40);
        rx_tight = ($urandom_range(0, 3) == 0);
      end
      rx_left--;
      hold = rx_tight ? 0 : $urandom_range(0, 16);
      if (squeeze_req && !squeeze_done) begin
        hold = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end
      if (hold > 0) begin
        res.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      got.send_valid = res.send_valid;
      got.send_time = res.send_time;
      got.send_last = res.send_last;
      got.blink = res.blink;
      got.mode = res.mode;
      got.phase = res.phase;
      check_outcome(got);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (res.valid && res.ready) || cfg_wr) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Event side: reset, directed table, then random phases under several settings
  initial begin
    dir_row_t        rows[$];
    logic [ID_W-1:0] phase_ids[NUM_PHASES];
    logic [PH_W-1:0] phase_slots[NUM_PHASES];
    evt.valid <= 1'b0;
    evt.kind <= '0;
    evt.advance <= '0;
    evt.sender_id <= '0;
    evt.sender_time <= '0;
    evt.sender_last <= 1'b0;
    evt.random_slot <= '0;
    node_ph = '0;
    node_md = MODE_CODE_BCAST;
    node_slot = '0;
    node_sent = '0;
    node_done = 1'b0;
    node_addr = '0;
    phase_ids = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd15, 4'd7};
    phase_slots = '{10'd0, 10'd1023, 10'd100, 10'd300, 10'd0, 10'd40};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Node 5, slot at the top; writes past the register list must change nothing
    write_reg(REG_NODE_ID, 10'd5);
    write_reg(REG_START_SLOT, 10'd1023);
    write_reg(REG_SPARE_A, 10'd0);
    write_reg(REG_SPARE_B, 10'd0);
    cfg_wr <= 1'b0;
    settings_used++;

    // Slot not reached, wrap, zero advance, nudges both ways, mode rules, a full burst
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 0), 1,
                          mk_res(0, 0, 0, 0, MODE_CODE_BCAST, 0)));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 1023, 0, 0, 0, 0), 1,
                          mk_res(0, 0, 0, 0, MODE_CODE_BCAST, 1023)));
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 0), 1,
                          mk_res(0, 0, 0, 0, MODE_CODE_BCAST, 1023)));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 1, 0, 0, 0, 0), 1,
                          mk_res(0, 0, 0, 1, MODE_CODE_BCAST, 0)));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 0, 0, 0, 0, 0), 1,
                          mk_res(0, 0, 0, 0, MODE_CODE_BCAST, 0)));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 15, 1023, 1, 1023), 1,
                          mk_res(0, 0, 0, 0, MODE_CODE_BCAST, 204)));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 15, 0, 0, 0), 1,
                          mk_res(0, 0, 0, 1, MODE_CODE_BCAST, 164)));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 5, 164, 1, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 4, 163, 0, 200), 1,
                          mk_res(0, 0, 0, 0, MODE_CODE_LISTEN, 164)));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 4, 169, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 5, 0, 1, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 4, 132, 1, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 0, 1023, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 6, 0, 0, 1023), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 1023, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 1023, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 1023, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 1023), 1,
                          mk_res(1, 245, 1, 0, MODE_CODE_QUIET, 245)));
    rows.push_back(mk_row(mk_ev(KIND_UNUSED, 1023, 15, 1023, 1, 1023), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_RECV, 0, 4, 512, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_ADVANCE, 1023, 0, 0, 0, 0), 0, '0));
    rows.push_back(mk_row(mk_ev(KIND_SEND, 0, 0, 0, 0, 0), 0, '0));
    foreach (rows[i]) offer(rows[i].ev, 1'b0, rows[i].typed, rows[i].want);

    // Random phases, each under its own node id and start slot
    for (int k = 0; k < NUM_PHASES; k++) begin
      settle();
      if (k == NUM_PHASES - 1) begin
        phase_ids[k] = ID_W'($urandom_range(0, 15));
        phase_slots[k] = PH_W'($urandom_range(0, 255));
      end
      write_reg(REG_NODE_ID, CFG_DATA_W'(phase_ids[k]));
      write_reg(REG_START_SLOT, CFG_DATA_W'(phase_slots[k]));
      cfg_wr <= 1'b0;
      settings_used++;
      if (k == SQUEEZE_PHASE) squeeze_req = 1'b1;
      for (int j = 0; j < PHASE_EVENTS; j++) begin
        offer(rand_event(), (k == SQUEEZE_PHASE) && (j < SQUEEZE_EVENTS), 1'b0, '0);
      end
    end

    // Drain and report
    settle();
    repeat (4) @(posedge clk);
    $display("Ran %0d events over %0d node settings; %0d results checked", events_sent,
             settings_used, results_checked);
    $display("Saw %0d broadcasts and %0d blinks; input held off %0d cycles", sends_seen,
             blinks_seen, stall_cycles);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ffs_pkg.sv
hdl/ffs_evt_if.sv
hdl/ffs_res_if.sv
hdl/ffs_in_stage.sv
hdl/ffs_core.sv
hdl/firefly_slot_sync_node.sv
bench/firefly_slot_sync_node_test.sv
